@@ rtl/core/fba_pkg.sv @@
// Shared constants and types for the frame bitmap allocator.
// Used by the bitmap RAM, the scan engine and the top level; no dependencies.
package fba_pkg;

    // Bitmap geometry.
    localparam int NUM_FRAMES = 1024;
    localparam int WORD_BITS  = 16;
    localparam int NUM_WORDS  = NUM_FRAMES / WORD_BITS;
    localparam int ADDR_W     = $clog2(NUM_WORDS);
    localparam int OFF_W      = $clog2(WORD_BITS);
    localparam int FRAME_W    = $clog2(NUM_FRAMES);
    localparam int CNT_W      = $clog2(NUM_WORDS + 1);

    // Width of the range bounds on the command port.
    localparam int RANGE_W    = 11;
    localparam int ACTION_W   = 2;

    // Frame 0 of a word sits in its top bit.
    localparam logic [WORD_BITS-1:0] TOP_BIT = {1'b1, {(WORD_BITS-1){1'b0}}};

    // Command codes; the remaining code leaves the bitmap alone.
    typedef enum logic [ACTION_W-1:0] {
        ACT_REPLACE = 2'd0,
        ACT_ADD     = 2'd1,
        ACT_ALLOC   = 2'd2
    } action_t;

    // Request from the engine to the bitmap RAM.
    typedef struct packed {
        logic                 rd_en;
        logic [ADDR_W-1:0]    rd_addr;
        logic                 wr_en;
        logic [ADDR_W-1:0]    wr_addr;
        logic [WORD_BITS-1:0] wr_data;
    } fba_mem_req_t;

endpackage

@@ rtl/core/frame_bitmap_allocator.sv @@
// A range command sweeps every bitmap word before done; an allocation stops at the first
// word with a free frame, or after the last word; an unknown command changes nothing.
// The bitmap RAM is read and written once a cycle, one word each.
// One command at a time: busy drops in the cycle that done is high, so a new command
// may be accepted there. The receiver cannot stall; each result shows for one cycle.
// Reset (rst_n, asynchronous, active low) leaves every frame in use.
module frame_bitmap_allocator
    import fba_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [ACTION_W-1:0] action,
    input  logic [RANGE_W-1:0]  range_start,
    input  logic [RANGE_W-1:0]  range_end,
    output logic                busy,
    output logic                done,
    output logic [FRAME_W-1:0]  frame_index,
    output logic                found
);

    fba_mem_req_t         mem_req;
    logic [WORD_BITS-1:0] rd_data;

    // Command sequencer.
    fba_engine u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .action      (action),
        .range_start (range_start),
        .range_end   (range_end),
        .busy        (busy),
        .done        (done),
        .frame_index (frame_index),
        .found       (found),
        .mem_req     (mem_req),
        .rd_data     (rd_data)
    );

    // Free-frame bitmap.
    fba_bitmap_ram u_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mem_req),
        .rd_data (rd_data)
    );

endmodule

@@ rtl/core/fba_bitmap_ram.sv @@
// Free-frame bitmap storage: one synchronous RAM word per 16 frames.
// Depends on fba_pkg. Per-word valid bits make unwritten words read as zero.
module fba_bitmap_ram
    import fba_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  fba_mem_req_t         req,
    output logic [WORD_BITS-1:0] rd_data
);

    logic [WORD_BITS-1:0] mem_reg [NUM_WORDS];
    logic [NUM_WORDS-1:0] valid_reg;
    logic [WORD_BITS-1:0] rd_word_reg;
    logic                 rd_hit_reg;

    // Storage array: one write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem_reg[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_word_reg <= mem_reg[req.rd_addr];
        end
    end

    // Valid bits: cleared at reset, set by the first write of a word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_hit_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_hit_reg <= valid_reg[req.rd_addr];
            end
        end
    end

    // A word never written holds no free frames.
    assign rd_data = rd_hit_reg ? rd_word_reg : '0;

endmodule

@@ rtl/core/fba_engine.sv @@
// Command sequencer: sweeps the bitmap for range updates and scans it for allocation.
// Depends on fba_pkg; drives the bitmap RAM through an fba_mem_req_t request.
module fba_engine
    import fba_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [ACTION_W-1:0]  action,
    input  logic [RANGE_W-1:0]   range_start,
    input  logic [RANGE_W-1:0]   range_end,
    output logic                 busy,
    output logic                 done,
    output logic [FRAME_W-1:0]   frame_index,
    output logic                 found,
    output fba_mem_req_t         mem_req,
    input  logic [WORD_BITS-1:0] rd_data
);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t               state_reg, state_next;
    logic [ACTION_W-1:0]  act_reg, act_next;
    logic [RANGE_W-1:0]   first_reg, first_next;
    logic [RANGE_W-1:0]   last_reg, last_next;
    logic [CNT_W-1:0]     issue_cnt_reg, issue_cnt_next;
    logic                 pend_valid_reg, pend_valid_next;
    logic [ADDR_W-1:0]    pend_addr_reg, pend_addr_next;
    logic                 done_reg, done_next;
    logic [FRAME_W-1:0]   frame_index_reg, frame_index_next;
    logic                 found_reg, found_next;

    logic [WORD_BITS-1:0] range_mask;
    logic [WORD_BITS-1:0] merged_word;
    logic [WORD_BITS-1:0] cleared_word;
    logic                 word_hit;
    logic [OFF_W-1:0]     hit_off;
    logic                 last_word;

    // Frames of the returned word that fall inside [first, last).
    always_comb
    begin
        for (int j = 0; j < WORD_BITS; j++)
        begin
            range_mask[j] =
                (RANGE_W'({pend_addr_reg, OFF_W'(WORD_BITS - 1 - j)}) >= first_reg) &&
                (RANGE_W'({pend_addr_reg, OFF_W'(WORD_BITS - 1 - j)}) < last_reg);
        end
    end

    // Replace mode drops the old contents; add mode keeps them.
    assign merged_word = ((act_reg == ACT_ADD) ? rd_data : '0) | range_mask;

    // Lowest-numbered free frame of the returned word (highest set bit).
    always_comb
    begin
        word_hit = 1'b0;
        hit_off  = '0;
        for (int k = WORD_BITS - 1; k >= 0; k--)
        begin
            if (rd_data[WORD_BITS - 1 - k])
            begin
                word_hit = 1'b1;
                hit_off  = OFF_W'(k);
            end
        end
    end

    assign cleared_word = rd_data & ~(TOP_BIT >> hit_off);
    assign last_word    = (pend_addr_reg == ADDR_W'(NUM_WORDS - 1));

    // Next-state logic: one read issued and one returned word handled per cycle.
    always_comb
    begin
        state_next       = state_reg;
        act_next         = act_reg;
        first_next       = first_reg;
        last_next        = last_reg;
        issue_cnt_next   = issue_cnt_reg;
        pend_valid_next  = 1'b0;
        pend_addr_next   = pend_addr_reg;
        done_next        = 1'b0;
        frame_index_next = '0;
        found_next       = 1'b0;
        mem_req          = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    act_next       = action;
                    first_next     = range_start;
                    last_next      = range_end;
                    issue_cnt_next = '0;
                    if (action == ACT_REPLACE || action == ACT_ADD || action == ACT_ALLOC)
                    begin
                        state_next = ST_RUN;
                    end
                    else
                    begin
                        // Unknown command: report at once with nothing changed.
                        done_next = 1'b1;
                    end
                end
            end

            ST_RUN:
            begin
                // Read side: walk the words in order.
                if (issue_cnt_reg < CNT_W'(NUM_WORDS))
                begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = issue_cnt_reg[ADDR_W-1:0];
                    issue_cnt_next  = issue_cnt_reg + 1'b1;
                    pend_valid_next = 1'b1;
                    pend_addr_next  = issue_cnt_reg[ADDR_W-1:0];
                end

                // Modify and store the previous cycle's word unless alloc misses.
                if (pend_valid_reg)
                begin
                    if (act_reg == ACT_ALLOC)
                    begin
                        if (word_hit)
                        begin
                            mem_req.wr_en    = 1'b1;
                            mem_req.wr_addr  = pend_addr_reg;
                            mem_req.wr_data  = cleared_word;
                            frame_index_next = {pend_addr_reg, hit_off};
                            found_next       = 1'b1;
                            done_next        = 1'b1;
                            pend_valid_next  = 1'b0;
                            state_next       = ST_IDLE;
                        end
                        else if (last_word)
                        begin
                            done_next       = 1'b1;
                            pend_valid_next = 1'b0;
                            state_next      = ST_IDLE;
                        end
                    end
                    else
                    begin
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_addr = pend_addr_reg;
                        mem_req.wr_data = merged_word;
                        if (last_word)
                        begin
                            done_next       = 1'b1;
                            pend_valid_next = 1'b0;
                            state_next      = ST_IDLE;
                        end
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            issue_cnt_reg   <= '0;
            pend_valid_reg  <= 1'b0;
            done_reg        <= 1'b0;
            found_reg       <= 1'b0;
            frame_index_reg <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            issue_cnt_reg   <= issue_cnt_next;
            pend_valid_reg  <= pend_valid_next;
            done_reg        <= done_next;
            found_reg       <= found_next;
            frame_index_reg <= frame_index_next;
        end
    end

    // Command payload and pipeline address hold no control meaning.
    always_ff @(posedge clk)
    begin
        act_reg       <= act_next;
        first_reg     <= first_next;
        last_reg      <= last_next;
        pend_addr_reg <= pend_addr_next;
    end

    assign busy        = (state_reg != ST_IDLE);
    assign done        = done_reg;
    assign frame_index = frame_index_reg;
    assign found       = found_reg;

endmodule
